[src/assert_macros.svh]
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

[src/rau_pkg.sv]
package rau_pkg;

	// Operation codes
	localparam logic [1:0] FUNC_ADD = 2'd0;
	localparam logic [1:0] FUNC_SUB = 2'd1;
	localparam logic [1:0] FUNC_MUL = 2'd2;
	localparam logic [1:0] FUNC_DIV = 2'd3;

	// Status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DIV0 = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;
	localparam logic [1:0] ST_ZDEN = 2'd3;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [31:0] a_num;
		logic signed [31:0] a_den;
		logic signed [31:0] b_num;
		logic signed [31:0] b_den;
	} req_t;

	typedef struct packed {
		logic signed [31:0] res_num;
		logic [30:0]        res_den;
		logic [1:0]         status;
	} rsp_t;

	// Command to the iterative gcd / divide unit
	typedef struct packed {
		logic start;
		logic div;
	} iter_cmd_t;

endpackage

[src/rau_mul.sv]
module rau_mul #(
	parameter int W = 32
) (
	input  logic           clk,
	input  logic [W-1:0]   a,
	input  logic [W-1:0]   b,
	output logic [2*W-1:0] prod_s1
);

	// Unsigned magnitude product, registered.
	always_ff @(posedge clk) begin
		prod_s1 <= (2*W)'(a) * (2*W)'(b);
	end

endmodule

[src/rau_iter.sv]
module rau_iter #(
	parameter int PW = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rau_pkg::iter_cmd_t cmd,
	input  logic [PW-1:0]     op_a,
	input  logic [PW-1:0]     op_b,
	output logic              done,
	output logic [PW-1:0]     res
);

	localparam int KW = $clog2(PW);

	logic          busy_q;
	logic          done_q;
	logic          div_q;
	logic [KW-1:0] k_q;
	logic [PW-1:0] u_q;
	logic [PW-1:0] v_q;
	logic [PW-1:0] y_q;
	logic [PW-1:0] g_q;
	logic [PW:0]   sub_a;
	logic [PW:0]   sub_b;
	logic [PW+1:0] diff;
	logic          ge;

	// One shared subtractor: gcd compare-subtract or restoring divide step.
	always_comb begin
		sub_a = div_q ? {u_q, v_q[PW-1]} : {1'b0, u_q};
		sub_b = {1'b0, (div_q ? y_q : v_q)};
		diff  = {1'b0, sub_a} - {1'b0, sub_b};
	end

	assign ge = !diff[PW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			div_q  <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (cmd.start) begin
					busy_q <= 1'b1;
					div_q  <= cmd.div;
					k_q    <= cmd.div ? KW'(PW - 1) : '0;
				end
			end else if (div_q) begin
				if (k_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					k_q <= k_q - KW'(1);
				end
			end else if (u_q == '0 || v_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else if (!u_q[0] && !v_q[0]) begin
				k_q <= k_q + KW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q) begin
			if (cmd.start) begin
				if (cmd.div) begin
					u_q <= '0;
					v_q <= op_a;
					y_q <= op_b;
				end else begin
					u_q <= op_a;
					v_q <= op_b;
				end
			end
		end else if (div_q) begin
			// remainder in u, dividend shifts out of v while quotient shifts in
			u_q <= ge ? diff[PW-1:0] : sub_a[PW-1:0];
			v_q <= {v_q[PW-2:0], ge};
		end else if (u_q == '0 || v_q == '0) begin
			g_q <= (u_q | v_q) << k_q;
		end else if (!u_q[0] && !v_q[0]) begin
			u_q <= u_q >> 1;
			v_q <= v_q >> 1;
		end else if (!u_q[0]) begin
			u_q <= u_q >> 1;
		end else if (!v_q[0]) begin
			v_q <= v_q >> 1;
		end else if (ge) begin
			u_q <= diff[PW-1:0];
		end else begin
			// swap so the larger odd value is subtracted from next
			u_q <= v_q;
			v_q <= u_q;
		end
	end

	assign done = done_q;
	assign res  = div_q ? v_q : g_q;

endmodule

[src/rational_arith_unit.sv]
// Exact arithmetic on signed fractions: add, subtract, multiply or divide two
// fractions and return the result in lowest terms with a positive denominator.
//
// Request channel (req_valid / req_ready / req): one word carries the
// operation and both operands. Response channel (rsp_valid / rsp_ready / rsp):
// one word per request carries numerator, denominator and status.
//
// One request is worked on at a time; req_ready is high only while the
// sequencer is idle. A single registered multiplier forms the cross products,
// then one shared subtractor runs a binary gcd and two restoring divisions of
// 2*VALUE_WIDTH steps each. The time from the taken request to response valid
// is data dependent, as the length of the gcd run depends on the operands.
// Zero denominators and divide by zero go from the idle state straight to the
// done state and skip the products, the gcd and the divisions.
//
// Reset clears the sequencer and the response valid. A finished word waits in
// the response register while the receiver stalls; the next request is taken
// as soon as the result has been handed to that register.
`include "assert_macros.svh"

module rational_arith_unit #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  rau_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output rau_pkg::rsp_t rsp
);

	import rau_pkg::*;

	localparam int W  = VALUE_WIDTH;
	localparam int PW = 2 * VALUE_WIDTH;

	localparam logic [PW-1:0] LIM    = PW'(1) << (W - 1);
	localparam logic [PW-1:0] LIM_M1 = LIM - PW'(1);

	// Sequencer states
	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_MUL0      = 4'd1;
	localparam logic [3:0] S_MUL1      = 4'd2;
	localparam logic [3:0] S_MUL2      = 4'd3;
	localparam logic [3:0] S_MUL3      = 4'd4;
	localparam logic [3:0] S_ABS       = 4'd5;
	localparam logic [3:0] S_GCD       = 4'd6;
	localparam logic [3:0] S_GCD_WAIT  = 4'd7;
	localparam logic [3:0] S_DIVN      = 4'd8;
	localparam logic [3:0] S_DIVN_WAIT = 4'd9;
	localparam logic [3:0] S_DIVD      = 4'd10;
	localparam logic [3:0] S_DIVD_WAIT = 4'd11;
	localparam logic [3:0] S_FIN       = 4'd12;
	localparam logic [3:0] S_DONE      = 4'd13;

	logic [3:0]    state_q;
	logic [1:0]    func_q;
	logic [W-1:0]  an_mag_q, ad_mag_q, bn_mag_q, bd_mag_q;
	logic          an_neg_q, ad_neg_q, bn_neg_q, bd_neg_q;
	logic [PW:0]   nsig_q;
	logic [PW:0]   tsig_q;
	logic [PW-1:0] dmag_q;
	logic          dneg_q;
	logic [PW-1:0] nmag_q;
	logic          nneg_q;
	logic [PW-1:0] g_q;
	logic [PW-1:0] nq_q;
	logic [PW-1:0] dq_q;
	rsp_t          res_q;
	rsp_t          rsp_q;
	logic          rsp_valid_q;

	// operand decode
	logic [W-1:0]  an_raw, ad_raw, bn_raw, bd_raw;
	logic [W-1:0]  an_mag, ad_mag, bn_mag, bd_mag;
	logic          zden;
	logic          div0;

	// product path
	logic [W-1:0]  mul_a, mul_b;
	logic [PW-1:0] prod_s1;
	logic [PW:0]   prod_ext;
	logic [PW:0]   prod_neg;
	logic          s0, s1, addsub;

	// reduction and result
	logic [PW:0]        nsig_neg;
	logic [PW-1:0]      nsig_abs;
	iter_cmd_t          iter_cmd;
	logic [PW-1:0]      iter_a, iter_b;
	logic               iter_done;
	logic [PW-1:0]      iter_res;
	logic               res_neg;
	logic               ovf;
	logic signed [PW:0] nres_s;
	logic               rsp_load;

	// checker helpers
	logic               rsp_zero;
	logic               iter_wait;

	// Take the low VALUE_WIDTH bits of each field as two's complement.
	assign an_raw = req.a_num[W-1:0];
	assign ad_raw = req.a_den[W-1:0];
	assign bn_raw = req.b_num[W-1:0];
	assign bd_raw = req.b_den[W-1:0];
	assign an_mag = an_raw[W-1] ? -an_raw : an_raw;
	assign ad_mag = ad_raw[W-1] ? -ad_raw : ad_raw;
	assign bn_mag = bn_raw[W-1] ? -bn_raw : bn_raw;
	assign bd_mag = bd_raw[W-1] ? -bd_raw : bd_raw;
	assign zden   = (ad_raw == '0) || (bd_raw == '0);
	assign div0   = (req.func == FUNC_DIV) && (bn_raw == '0);

	// Product order: numerator term first, then the other cross term (add and
	// subtract) or the denominator, then the denominator for add and subtract.
	always_comb begin
		mul_a = ad_mag_q;
		mul_b = bd_mag_q;
		case (state_q)
			S_MUL0: begin
				mul_a = an_mag_q;
				mul_b = (func_q == FUNC_MUL) ? bn_mag_q : bd_mag_q;
			end
			S_MUL1: begin
				mul_a = ad_mag_q;
				mul_b = (func_q == FUNC_MUL) ? bd_mag_q : bn_mag_q;
			end
			default: begin
				mul_a = ad_mag_q;
				mul_b = bd_mag_q;
			end
		endcase
	end

	rau_mul #(
		.W(W)
	) u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_s1(prod_s1)
	);

	assign addsub   = (func_q == FUNC_ADD) || (func_q == FUNC_SUB);
	assign s0       = an_neg_q ^ ((func_q == FUNC_MUL) ? bn_neg_q : bd_neg_q);
	assign s1       = ad_neg_q ^ ((func_q == FUNC_MUL) ? bd_neg_q : bn_neg_q)
		^ (func_q == FUNC_SUB);
	assign prod_ext = {1'b0, prod_s1};
	assign prod_neg = -prod_ext;

	assign nsig_neg = -nsig_q;
	assign nsig_abs = nsig_q[PW] ? nsig_neg[PW-1:0] : nsig_q[PW-1:0];

	// Drive the gcd / divide unit: gcd(n, d), then n / g, then d / g.
	always_comb begin
		iter_cmd.start = (state_q == S_GCD) || (state_q == S_DIVN) || (state_q == S_DIVD);
		iter_cmd.div   = (state_q != S_GCD);
		iter_a         = (state_q == S_DIVD) ? dmag_q : nmag_q;
		iter_b         = (state_q == S_GCD) ? dmag_q : g_q;
	end

	rau_iter #(
		.PW(PW)
	) u_iter (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (iter_cmd),
		.op_a  (iter_a),
		.op_b  (iter_b),
		.done  (iter_done),
		.res   (iter_res)
	);

	// Range check of the reduced fraction; never wrap.
	assign res_neg = nneg_q ^ dneg_q;
	assign ovf     = (dq_q > LIM_M1) || (nq_q > (res_neg ? LIM : LIM_M1));
	assign nres_s  = res_neg ? $signed(-{1'b0, nq_q}) : $signed({1'b0, nq_q});

	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || rsp_ready);

	// Sequencer and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= (zden || div0) ? S_DONE : S_MUL0;
					end
				end
				S_MUL0: state_q <= S_MUL1;
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= addsub ? S_MUL3 : S_ABS;
				S_MUL3: state_q <= S_ABS;
				S_ABS: state_q <= (nsig_q == '0) ? S_DONE : S_GCD;
				S_GCD: state_q <= S_GCD_WAIT;
				S_GCD_WAIT: begin
					if (iter_done) begin
						state_q <= S_DIVN;
					end
				end
				S_DIVN: state_q <= S_DIVN_WAIT;
				S_DIVN_WAIT: begin
					if (iter_done) begin
						state_q <= S_DIVD;
					end
				end
				S_DIVD: state_q <= S_DIVD_WAIT;
				S_DIVD_WAIT: begin
					if (iter_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: state_q <= S_DONE;
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= res_q;
		end
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					func_q   <= req.func;
					an_mag_q <= an_mag;
					ad_mag_q <= ad_mag;
					bn_mag_q <= bn_mag;
					bd_mag_q <= bd_mag;
					an_neg_q <= an_raw[W-1];
					ad_neg_q <= ad_raw[W-1];
					bn_neg_q <= bn_raw[W-1];
					bd_neg_q <= bd_raw[W-1];
					// a zero denominator wins over divide by zero
					if (zden) begin
						res_q <= '{res_num: '0, res_den: '0, status: ST_ZDEN};
					end else begin
						res_q <= '{res_num: '0, res_den: '0, status: ST_DIV0};
					end
				end
			end
			S_MUL1: nsig_q <= s0 ? prod_neg : prod_ext;
			S_MUL2: begin
				if (addsub) begin
					tsig_q <= s1 ? prod_neg : prod_ext;
				end else begin
					dmag_q <= prod_s1;
					dneg_q <= s1;
				end
			end
			S_MUL3: begin
				dmag_q <= prod_s1;
				dneg_q <= ad_neg_q ^ bd_neg_q;
				nsig_q <= nsig_q + tsig_q;
			end
			S_ABS: begin
				nmag_q <= nsig_abs;
				nneg_q <= nsig_q[PW];
				// zero result comes out as 0/1
				res_q  <= '{res_num: '0, res_den: 31'd1, status: ST_OK};
			end
			S_GCD_WAIT: begin
				if (iter_done) begin
					g_q <= iter_res;
				end
			end
			S_DIVN_WAIT: begin
				if (iter_done) begin
					nq_q <= iter_res;
				end
			end
			S_DIVD_WAIT: begin
				if (iter_done) begin
					dq_q <= iter_res;
				end
			end
			S_FIN: begin
				if (ovf) begin
					res_q <= '{res_num: '0, res_den: '0, status: ST_OVF};
				end else begin
					res_q <= '{res_num: 32'(nres_s), res_den: 31'(dq_q), status: ST_OK};
				end
			end
			default: ;
		endcase
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign rsp_zero  = (rsp.res_num == '0) && (rsp.res_den == '0);
	assign iter_wait = (state_q == S_GCD_WAIT) || (state_q == S_DIVN_WAIT)
		|| (state_q == S_DIVD_WAIT);

	// Hold off a second word straight after one is taken.
	`ASSERT_NXT(a_busy_after_accept, clk, arst_n, req_valid && req_ready, !req_ready)
	// Error words carry a zero fraction.
	`ASSERT_IMP(a_err_zero, clk, arst_n, rsp_valid && rsp.status != ST_OK, rsp_zero)
	// Good words always carry a nonzero denominator.
	`ASSERT_IMP(a_ok_den, clk, arst_n, rsp_valid && rsp.status == ST_OK, rsp.res_den != '0)
	// The shared unit only finishes while the sequencer waits on it.
	`ASSERT_IMP(a_iter_wait, clk, arst_n, iter_done, iter_wait)

endmodule
